FILE: rtl/dotb_pkg.sv
// Shared types and constants for the deadline-ordered timer bank.
// Used by every module under rtl; depends on nothing.
package dotb_pkg;

	localparam int TIMERS = 8;
	localparam int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;  // slot index width
	localparam int DW     = 49;                                  // deadline width
	localparam int NW     = 48;                                  // time width
	localparam int AW     = 4;                                   // APB address width

	// operation codes
	localparam logic [2:0] FN_TICK    = 3'd0;
	localparam logic [2:0] FN_CREATE  = 3'd1;
	localparam logic [2:0] FN_DELETE  = 3'd2;
	localparam logic [2:0] FN_START   = 3'd3;
	localparam logic [2:0] FN_STOP    = 3'd4;
	localparam logic [2:0] FN_SETPER  = 3'd5;
	localparam logic [2:0] FN_SETRLD  = 3'd6;
	localparam logic [2:0] FN_UNDEF   = 3'd7;

	// register indexes (word address)
	localparam logic [1:0] REG_PRECISION = 2'd0;
	localparam logic [1:0] REG_CLOCKS    = 2'd1;
	localparam logic [1:0] REG_MIN_WAIT  = 2'd2;

	localparam logic [19:0] RST_PRECISION = 20'd1;
	localparam logic [9:0]  RST_CLOCKS    = 10'd1;
	localparam logic [31:0] RST_MIN_WAIT  = 32'd1000;

	typedef struct packed {
		logic [2:0]    func;
		logic [2:0]    timer_index;
		logic [31:0]   value;
		logic [NW-1:0] now_us;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [2:0]  fired_index;
		logic        ok;
		logic        wait_forever;
		logic [31:0] wait_ticks;
		logic        last;
	} rsp_t;

	// candidate handed down the cell chain
	typedef struct packed {
		logic          valid;
		logic [DW-1:0] deadline;
		logic [IW-1:0] index;
	} tok_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic          op_valid;
		logic [2:0]    func;
		logic [IW-1:0] op_idx;
		logic [31:0]   value;
		logic [NW-1:0] now;
		logic [DW-1:0] limit;
		logic          wait_mode;
		logic          fire;
		logic [IW-1:0] fire_idx;
		logic          clear_done;
	} ctl_t;

endpackage

FILE: rtl/dotb_cell.sv
// One timer slot of the chain: holds period, deadline and flags, and
// passes the earlier of its own candidate and its left neighbor's on.
// Depends on dotb_pkg.
module dotb_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [dotb_pkg::IW-1:0] my_index,
	input  dotb_pkg::ctl_t          ctl,
	input  dotb_pkg::tok_t          tok_in,
	output dotb_pkg::tok_t          tok_out
);
	import dotb_pkg::*;

	logic [31:0]   period_q;
	logic [DW-1:0] deadline_q;
	logic          armed_q;
	logic          periodic_q;
	logic          done_q;
	tok_t          tok_q;

	logic          op_sel;
	logic          fire_sel;
	logic          eligible;
	logic          take;
	logic [DW-1:0] now_ext;
	logic [DW-1:0] rearm_dl;
	logic [DW-1:0] setp_dl;

	assign now_ext  = {1'b0, ctl.now};
	assign rearm_dl = now_ext + DW'(period_q);
	assign setp_dl  = now_ext + DW'(ctl.value);

	assign op_sel   = ctl.op_valid && (ctl.op_idx == my_index);
	assign fire_sel = ctl.fire && (ctl.fire_idx == my_index);

	// fire scan: armed, not yet fired, inside the margin; wait scan: armed
	assign eligible = armed_q && (ctl.wait_mode || (!done_q && (deadline_q < ctl.limit)));
	// strict compare: ties stay with the lower index coming from the left
	assign take     = eligible && (!tok_in.valid || (deadline_q < tok_in.deadline));

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= '0;
			deadline_q <= '0;
			armed_q    <= 1'b0;
			periodic_q <= 1'b0;
			done_q     <= 1'b0;
			tok_q      <= '0;
		end else begin
			if (take) begin
				tok_q.valid    <= 1'b1;
				tok_q.deadline <= deadline_q;
				tok_q.index    <= my_index;
			end else begin
				tok_q <= tok_in;
			end

			if (ctl.clear_done) begin
				done_q <= 1'b0;
			end

			if (op_sel) begin
				unique case (ctl.func)
					FN_CREATE: begin
						period_q   <= ctl.value;
						periodic_q <= 1'b1;
						armed_q    <= 1'b0;
						deadline_q <= '0;
					end
					FN_DELETE: begin
						period_q   <= '0;
						periodic_q <= 1'b0;
						armed_q    <= 1'b0;
						deadline_q <= '0;
					end
					FN_START: begin
						if (!armed_q) begin
							armed_q    <= 1'b1;
							deadline_q <= rearm_dl;
						end
					end
					FN_STOP: begin
						armed_q    <= 1'b0;
						deadline_q <= '0;
					end
					FN_SETPER: begin
						period_q <= ctl.value;
						if (armed_q) begin
							deadline_q <= setp_dl;
						end
					end
					FN_SETRLD: begin
						periodic_q <= (ctl.value != 32'd0);
					end
					default: begin
					end
				endcase
			end else if (fire_sel) begin
				done_q <= 1'b1;
				if (periodic_q) begin
					deadline_q <= rearm_dl;
				end else begin
					armed_q    <= 1'b0;
					deadline_q <= '0;
				end
			end
		end
	end

endmodule

FILE: rtl/dotb_seq.sv
// Sequencer: takes a request, steers the cell chain through fire and wait
// scans, converts the wait to counter clocks and drives the result port.
// Depends on dotb_pkg.
module dotb_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dotb_pkg::req_t   req,
	output logic             busy,
	output logic             strobe,
	output dotb_pkg::rsp_t   rsp,
	input  logic [19:0]      cfg_precision,
	input  logic [9:0]       cfg_clocks,
	input  logic [31:0]      cfg_min_wait,
	input  dotb_pkg::tok_t   tok,
	output dotb_pkg::ctl_t   ctl
);
	import dotb_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_APPLY  = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DECIDE = 6'b001000,
		S_MUL    = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cnt_q;
	req_t          item_q;
	logic [DW-1:0] limit_q;
	logic          ok_q;
	logic          wait_mode_q;
	logic          any_q;
	logic          sat_q;
	logic [31:0]   diff_q;
	logic [41:0]   prod_q;
	logic          strobe_q;
	rsp_t          rsp_q;

	logic          accept;
	logic          req_ok;
	logic [DW-1:0] now_ext;
	logic [DW-1:0] diff_full;
	logic          sat;
	logic [31:0]   ticks_sat;
	logic [31:0]   ticks;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign strobe  = strobe_q;
	assign rsp     = rsp_q;
	assign now_ext = {1'b0, item_q.now_us};

	assign req_ok = (req.func != FN_UNDEF) &&
		((req.func == FN_TICK) || (int'(req.timer_index) < TIMERS));

	assign diff_full = (tok.deadline > now_ext) ? (tok.deadline - now_ext) : '0;

	assign sat       = (sat_q && (cfg_clocks != 10'd0)) || (|prod_q[41:32]);
	assign ticks_sat = sat ? '1 : prod_q[31:0];
	assign ticks     = (ticks_sat < cfg_min_wait) ? cfg_min_wait : ticks_sat;

	always_comb begin
		ctl            = '0;
		ctl.op_valid   = (state_q == S_APPLY) && ok_q && (item_q.func != FN_TICK);
		ctl.func       = item_q.func;
		ctl.op_idx     = IW'(item_q.timer_index);
		ctl.value      = item_q.value;
		ctl.now        = item_q.now_us;
		ctl.limit      = limit_q;
		ctl.wait_mode  = wait_mode_q;
		ctl.fire       = (state_q == S_DECIDE) && !wait_mode_q && tok.valid;
		ctl.fire_idx   = tok.index;
		ctl.clear_done = (state_q == S_APPLY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ok_q        <= 1'b0;
			wait_mode_q <= 1'b0;
			any_q       <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ok_q        <= req_ok;
						wait_mode_q <= 1'b0;
						state_q     <= S_APPLY;
					end
				end
				S_APPLY: begin
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// chain output settles one cell per cycle
					if (cnt_q == IW'(TIMERS - 1)) begin
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (wait_mode_q) begin
						any_q   <= tok.valid;
						state_q <= S_MUL;
					end else if (tok.valid) begin
						strobe_q <= 1'b1;
						state_q  <= S_SCAN;
					end else begin
						wait_mode_q <= 1'b1;
						state_q     <= S_SCAN;
					end
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= req;
			limit_q <= DW'(req.now_us) + DW'(cfg_precision);
		end
		if (state_q == S_DECIDE) begin
			sat_q  <= |diff_full[DW-1:32];
			diff_q <= diff_full[31:0];
			if (!wait_mode_q) begin
				rsp_q.fired        <= 1'b1;
				rsp_q.fired_index  <= 3'(tok.index);
				rsp_q.ok           <= ok_q;
				rsp_q.wait_forever <= 1'b0;
				rsp_q.wait_ticks   <= '0;
				rsp_q.last         <= 1'b0;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= 42'(diff_q) * 42'(cfg_clocks);
		end
		if (state_q == S_FIN) begin
			rsp_q.fired        <= 1'b0;
			rsp_q.fired_index  <= '0;
			rsp_q.ok           <= ok_q;
			rsp_q.wait_forever <= !any_q;
			rsp_q.wait_ticks   <= any_q ? ticks : '0;
			rsp_q.last         <= 1'b1;
		end
	end

`ifndef SYNTH
	a_last_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.last |-> $past(state_q == S_FIN))
		else $error("closing record without finishing step");
	a_busy_ends_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && rsp.last)
		else $error("request finished without a closing record");
	a_fire_record_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.fired |-> !rsp.last && !rsp.wait_forever && (rsp.wait_ticks == 32'd0))
		else $error("fired record carries status fields");
	a_accept_applies: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_APPLY)
		else $error("accepted request not applied");
`endif

endmodule

FILE: rtl/deadline_ordered_timer_bank.sv
// Top level of the deadline-ordered timer bank: configuration registers,
// the row of timer cells and the sequencer. Depends on dotb_pkg, dotb_cell
// and dotb_seq.
//
//  port group      direction  handshake                    payload
//  request         in         start & !busy                req   (dotb_pkg::req_t)
//  result          out        strobe, one cycle, no stall  rsp   (dotb_pkg::rsp_t)
//  configuration   in/out     APB, psel & penable & pwrite paddr, pwdata, prdata
//
// A request keeps busy high through one search of the cell chain for each
// timer that fires, one search that finds none left to fire and one for
// the next deadline. A candidate moves one cell per cycle, so each search
// waits until the chain has settled. Results leave through a register in
// the cycle after they are formed, and the receiver cannot stall them.
// Reset clears all timers and loads the register defaults (precision 1,
// one clock per microsecond, minimum wait 1000).
module deadline_ordered_timer_bank (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  dotb_pkg::req_t          req,
	output logic                    strobe,
	output dotb_pkg::rsp_t          rsp,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [dotb_pkg::AW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import dotb_pkg::*;

	logic [19:0] precision_q;   // early-fire margin, microseconds
	logic [9:0]  clocks_q;      // counter clocks per microsecond
	logic [31:0] min_wait_q;    // floor on the reported wait

	logic        cfg_wr;
	logic [1:0]  cfg_sel;

	ctl_t        ctl;
	tok_t        chain [TIMERS+1];  // chain[i] enters cell i

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_sel = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= RST_PRECISION;
			clocks_q    <= RST_CLOCKS;
			min_wait_q  <= RST_MIN_WAIT;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_PRECISION: precision_q <= pwdata[19:0];
				REG_CLOCKS:    clocks_q    <= pwdata[9:0];
				REG_MIN_WAIT:  min_wait_q  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_PRECISION: prdata = {12'd0, precision_q};
			REG_CLOCKS:    prdata = {22'd0, clocks_q};
			REG_MIN_WAIT:  prdata = min_wait_q;
			default:       prdata = '0;
		endcase
	end

	// ---------------- timer cells ----------------
	// Nothing enters the left end; the earliest eligible deadline leaves
	// the right end once the chain has settled.
	assign chain[0] = '0;

	for (genvar i = 0; i < TIMERS; i++) begin : g_cell
		dotb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_index (IW'(i)),
			.ctl      (ctl),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	// ---------------- sequencer ----------------
	dotb_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req           (req),
		.busy          (busy),
		.strobe        (strobe),
		.rsp           (rsp),
		.cfg_precision (precision_q),
		.cfg_clocks    (clocks_q),
		.cfg_min_wait  (min_wait_q),
		.tok           (chain[TIMERS]),
		.ctl           (ctl)
	);

endmodule
